>>> rtl/mnee_pkg.sv
// Package for the MIDI note event extractor: word types for both channels,
// parse phase, result kind and error code enums, and status nibble constants.
// No dependencies.
package mnee_pkg;

  typedef enum logic [2:0] {
    PH_DELTA_START = 3'd0,
    PH_DELTA_MORE  = 3'd1,
    PH_STATUS      = 3'd2,
    PH_NOTE1       = 3'd3,
    PH_NOTE2       = 3'd4,
    PH_SKIP        = 3'd5,
    PH_META_TYPE   = 3'd6,
    PH_META_LEN    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NOTE    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FATAL = 2'd1,
    ERR_TRUNC = 2'd2,
    ERR_WARN  = 2'd3
  } err_e;

  localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
  localparam logic [3:0] STAT_KEY_TOUCH  = 4'hA;
  localparam logic [3:0] STAT_CONTROL    = 4'hB;
  localparam logic [3:0] STAT_PROGRAM    = 4'hC;
  localparam logic [3:0] STAT_CHAN_TOUCH = 4'hD;
  localparam logic [3:0] STAT_PITCH      = 4'hE;
  localparam logic [3:0] STAT_SYSTEM     = 4'hF;
  localparam logic [7:0] STAT_META       = 8'hFF;

  localparam int unsigned NOTE_COUNT_W = 24;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_W        = 2;
  localparam int unsigned CNT_W        = 3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_track;
  } in_word_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    note_on;
    logic [3:0]              channel;
    logic [7:0]              note_number;
    logic [7:0]              velocity;
    logic [31:0]             delta_time;
    logic [NOTE_COUNT_W-1:0] note_count;
    err_e                    error_code;
    logic                    last;
  } out_word_t;

endpackage

>>> rtl/midi_note_event_extractor_top.sv
// Result words are written into the result queue when the byte that causes them is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that causes two results
// writes both at once into a four-word result queue (ready while at least two slots are free).
// Reset: asynchronous active low; parse state, note count and queue clear at once.
// Top level of the MIDI track note event extractor; uses mnee_pkg.
// Holds the byte parser and the result queue.
module midi_note_event_extractor_top
  import mnee_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  phase_e                phase_q, phase_d, phase_nx;
  logic [31:0]           delta_q, delta_d, delta_nx;
  logic [7:0]            status_q, status_d, status_nx;
  logic [7:0]            first_q, first_d, first_nx;
  logic [7:0]            skip_q, skip_d, skip_nx;
  logic [COUNT_BITS-1:0] total_q, total_d, total_nx;
  logic                  halted_q, halted_d, halted_nx;

  out_word_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;

  logic                  accept;
  logic                  pop;
  logic [1:0]            push_n;
  out_word_t             res0, res1;
  out_word_t             blank;
  logic                  prim_v;
  out_word_t             prim;
  logic [31:0]           total32;
  logic [7:0]            b;
  logic                  eot;

  assign b      = in_word_i.byte_value;
  assign eot    = in_word_i.end_of_track;
  assign accept = in_valid_i && in_ready_o;
  assign pop    = out_valid_o && out_ready_i;

  assign in_ready_o  = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_word_o  = fifo_q[head_q];

  // Next parse state for the byte on the input.
  always_comb begin
    phase_nx  = phase_q;
    delta_nx  = delta_q;
    status_nx = status_q;
    first_nx  = first_q;
    skip_nx   = skip_q;
    total_nx  = total_q;
    halted_nx = halted_q;
    if (!halted_q) begin
      unique case (phase_q) inside
        PH_DELTA_START, PH_DELTA_MORE: begin
          delta_nx = (phase_q == PH_DELTA_START) ? {25'd0, b[6:0]}
                                                  : {delta_q[24:0], b[6:0]};
          phase_nx = b[7] ? PH_DELTA_MORE : PH_STATUS;
        end
        PH_STATUS: begin
          if (!b[7]) begin
            halted_nx = 1'b1;
          end else begin
            status_nx = b;
            unique case (b[7:4]) inside
              STAT_NOTE_OFF, STAT_NOTE_ON: begin
                phase_nx = PH_NOTE1;
              end
              STAT_PROGRAM, STAT_CHAN_TOUCH: begin
                skip_nx  = 8'd1;
                phase_nx = PH_SKIP;
              end
              STAT_KEY_TOUCH, STAT_CONTROL, STAT_PITCH: begin
                skip_nx  = 8'd2;
                phase_nx = PH_SKIP;
              end
              default: begin
                phase_nx = (b == STAT_META) ? PH_META_TYPE : PH_DELTA_START;
              end
            endcase
          end
        end
        PH_NOTE1: begin
          first_nx = b;
          phase_nx = PH_NOTE2;
        end
        PH_NOTE2: begin
          if (total_q != {COUNT_BITS{1'b1}}) begin
            total_nx = total_q + COUNT_BITS'(1);
          end
          phase_nx = PH_DELTA_START;
        end
        PH_SKIP: begin
          if (skip_q <= 8'd1) begin
            skip_nx  = 8'd0;
            phase_nx = PH_DELTA_START;
          end else begin
            skip_nx = skip_q - 8'd1;
          end
        end
        PH_META_TYPE: begin
          phase_nx = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (b == 8'd0) begin
            phase_nx = PH_DELTA_START;
          end else begin
            skip_nx  = b;
            phase_nx = PH_SKIP;
          end
        end
        default: begin
          phase_nx = PH_DELTA_START;
        end
      endcase
    end
  end

  // The last byte of a track returns the parse state and note count to their reset values.
  always_comb begin
    if (eot) begin
      phase_d  = PH_DELTA_START;
      delta_d  = '0;
      status_d = '0;
      first_d  = '0;
      skip_d   = '0;
      total_d  = '0;
      halted_d = 1'b0;
    end else begin
      phase_d  = phase_nx;
      delta_d  = delta_nx;
      status_d = status_nx;
      first_d  = first_nx;
      skip_d   = skip_nx;
      total_d  = total_nx;
      halted_d = halted_nx;
    end
  end

  // Result words caused by the byte on the input.
  always_comb begin
    total32            = 32'(total_nx);
    blank              = '0;
    blank.kind         = KIND_ERROR;
    blank.error_code   = ERR_NONE;
    blank.note_count   = total32[NOTE_COUNT_W-1:0];
    prim               = blank;
    prim_v             = 1'b0;
    if (!halted_q) begin
      unique case (phase_q)
        PH_STATUS: begin
          if (!b[7]) begin
            prim_v          = 1'b1;
            prim.error_code = ERR_FATAL;
          end else if (b[7:4] == STAT_SYSTEM && b != STAT_META) begin
            prim_v          = 1'b1;
            prim.error_code = ERR_WARN;
          end
        end
        PH_NOTE2: begin
          prim_v           = 1'b1;
          prim.kind        = KIND_NOTE;
          prim.note_on     = (status_q[7:4] == STAT_NOTE_ON) && (b != 8'd0);
          prim.channel     = status_q[3:0];
          prim.note_number = first_q;
          prim.velocity    = b;
          prim.delta_time  = delta_q;
        end
        default: begin
          prim_v = 1'b0;
        end
      endcase
    end

    res0   = blank;
    res1   = blank;
    push_n = 2'd0;
    if (eot && !halted_nx) begin
      res1.kind = KIND_SUMMARY;
      res1.last = 1'b1;
      if (prim_v) begin
        res0   = prim;
        push_n = 2'd2;
      end else if (phase_nx != PH_DELTA_START) begin
        res0.error_code = ERR_TRUNC;
        push_n          = 2'd2;
      end else begin
        res0   = res1;
        push_n = 2'd1;
      end
    end else if (prim_v) begin
      res0      = prim;
      res0.last = 1'b1;
      push_n    = 2'd1;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  always_comb begin
    head_d  = pop ? head_q + PTR_W'(1) : head_q;
    tail_d  = tail_q + PTR_W'(push_n);
    count_d = count_q + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA_START;
      delta_q  <= '0;
      status_q <= '0;
      first_q  <= '0;
      skip_q   <= '0;
      total_q  <= '0;
      halted_q <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        delta_q  <= delta_d;
        status_q <= status_d;
        first_q  <= first_d;
        skip_q   <= skip_d;
        total_q  <= total_d;
        halted_q <= halted_d;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[tail_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[tail_q + PTR_W'(1)] <= res1;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && halted_q) |-> (push_n == 2'd0))
    else $error("A halted parser wrote a result word.");

  a_pair_ends_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (res1.kind == KIND_SUMMARY && res1.last && !res0.last))
    else $error("A result pair does not end with the track summary.");

  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_word_i.end_of_track) |=> (phase_q == PH_DELTA_START && !halted_q
                                             && total_q == '0))
    else $error("Track end did not restart the parser.");

  a_note_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind == KIND_NOTE) |-> (out_word_o.error_code == ERR_NONE))
    else $error("A note word carries an error code.");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for midi_note_event_extractor_top: feeds track bytes,
// predicts note, warning, error and summary words, and checks every output word.
// Depends on mnee_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
  import mnee_pkg::*;

  localparam int unsigned NOTES_W = 24;
  localparam longint unsigned NOTES_MAX = (64'd1 << NOTES_W) - 1;
  localparam logic [7:0] META_END = 8'h2F;
  localparam logic [7:0] SYS_FIRST = 8'hF0;
  localparam logic [7:0] SYS_LAST = 8'hFE;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  in_word_t   pending_q [$];
  out_word_t  expected_q [$];
  logic [7:0] track_bytes [$];

  phase_e      track_phase;
  logic [31:0] delta_sum;
  logic [7:0]  status_hold;
  logic [7:0]  key_hold;
  logic [7:0]  skip_count;
  logic [31:0] notes_seen;
  logic        stopped;

  int        mismatches = 0;
  int        bytes_taken = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        hold_left = 0;
  int        mode_left = 0;
  int        rx_tick = 0;
  logic      pressure_done = 1'b0;
  rx_mode_e  rx_mode = RX_OPEN;
  out_word_t oldest;

  midi_note_event_extractor_top #(
    .COUNT_BITS(NOTES_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    if (mismatches < 40) begin
      $display("%0t error: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic clear_track();
    track_phase = PH_DELTA_START;
    delta_sum = '0;
    status_hold = '0;
    key_hold = '0;
    skip_count = '0;
    notes_seen = '0;
    stopped = 1'b0;
  endtask

  function automatic out_word_t make_result(kind_e k, logic on, logic [3:0] ch,
                                            logic [7:0] key, logic [7:0] vel,
                                            logic [31:0] dt, err_e code);
    out_word_t r;
    r.kind = k;
    r.note_on = on;
    r.channel = ch;
    r.note_number = key;
    r.velocity = vel;
    r.delta_time = dt;
    r.note_count = notes_seen[NOTE_COUNT_W-1:0];
    r.error_code = code;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_results(input in_word_t w);
    out_word_t  res [2];
    int         n;
    logic [7:0] b;
    logic       on;
    n = 0;
    b = w.byte_value;
    if (stopped) begin
      if (w.end_of_track) begin
        clear_track();
      end
      return;
    end
    case (track_phase) inside
      PH_DELTA_START, PH_DELTA_MORE: begin
        if (track_phase == PH_DELTA_START) begin
          delta_sum = '0;
        end
        delta_sum = {delta_sum[24:0], b[6:0]};
        track_phase = b[7] ? PH_DELTA_MORE : PH_STATUS;
      end
      PH_STATUS: begin
        if (!b[7]) begin
          res[n] = make_result(KIND_ERROR, 1'b0, '0, '0, '0, '0, ERR_FATAL);
          n++;
          stopped = 1'b1;
        end else begin
          status_hold = b;
          case (b[7:4]) inside
            STAT_NOTE_OFF, STAT_NOTE_ON: begin
              track_phase = PH_NOTE1;
            end
            STAT_PROGRAM, STAT_CHAN_TOUCH: begin
              skip_count = 8'd1;
              track_phase = PH_SKIP;
            end
            STAT_KEY_TOUCH, STAT_CONTROL, STAT_PITCH: begin
              skip_count = 8'd2;
              track_phase = PH_SKIP;
            end
            default: begin
              if (b == STAT_META) begin
                track_phase = PH_META_TYPE;
              end else begin
                res[n] = make_result(KIND_ERROR, 1'b0, '0, '0, '0, '0, ERR_WARN);
                n++;
                track_phase = PH_DELTA_START;
              end
            end
          endcase
        end
      end
      PH_NOTE1: begin
        key_hold = b;
        track_phase = PH_NOTE2;
      end
      PH_NOTE2: begin
        on = (status_hold[7:4] == STAT_NOTE_ON) && (b != 8'd0);
        if (notes_seen < NOTES_MAX) begin
          notes_seen = notes_seen + 32'd1;
        end
        res[n] = make_result(KIND_NOTE, on, status_hold[3:0], key_hold, b, delta_sum,
                             ERR_NONE);
        n++;
        track_phase = PH_DELTA_START;
      end
      PH_SKIP: begin
        if (skip_count <= 8'd1) begin
          skip_count = '0;
          track_phase = PH_DELTA_START;
        end else begin
          skip_count = skip_count - 8'd1;
        end
      end
      PH_META_TYPE: begin
        track_phase = PH_META_LEN;
      end
      default: begin
        if (b == 8'd0) begin
          track_phase = PH_DELTA_START;
        end else begin
          skip_count = b;
          track_phase = PH_SKIP;
        end
      end
    endcase
    if (w.end_of_track) begin
      if (!stopped) begin
        if (track_phase != PH_DELTA_START) begin
          res[n] = make_result(KIND_ERROR, 1'b0, '0, '0, '0, '0, ERR_TRUNC);
          n++;
        end
        res[n] = make_result(KIND_SUMMARY, 1'b0, '0, '0, '0, '0, ERR_NONE);
        n++;
      end
      clear_track();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        res[i].last = 1'b1;
      end
      expected_q.push_back(res[i]);
    end
  endtask

  task automatic flush_track();
    in_word_t w;
    foreach (track_bytes[i]) begin
      w.byte_value = track_bytes[i];
      w.end_of_track = (i == track_bytes.size() - 1);
      pending_q.push_back(w);
    end
    track_bytes.delete();
  endtask

  task automatic put_delta();
    logic [7:0]  groups [$];
    logic [31:0] v;
    logic [6:0]  junk;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      v = $urandom_range(0, 127);
    end else if (pick < 8) begin
      v = $urandom_range(128, 16383);
    end else begin
      v = $urandom();
    end
    groups.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      groups.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    if (pick == 9) begin
      junk = 7'($urandom());
      groups.push_front({1'b1, junk});
    end
    foreach (groups[i]) begin
      track_bytes.push_back(groups[i]);
    end
  endtask

  task automatic put_event();
    int unsigned sel;
    int unsigned len;
    int unsigned r;
    logic [3:0]  ch;
    logic [7:0]  d;
    sel = $urandom_range(0, 49);
    ch = 4'($urandom_range(0, 15));
    if (sel < 24) begin
      track_bytes.push_back({($urandom_range(0, 1) ? STAT_NOTE_ON : STAT_NOTE_OFF), ch});
      d = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 127));
      track_bytes.push_back(d);
      r = $urandom_range(0, 7);
      if (r == 0) begin
        d = 8'd0;
      end else if (r == 1) begin
        d = 8'($urandom_range(128, 255));
      end else begin
        d = 8'($urandom_range(1, 127));
      end
      track_bytes.push_back(d);
    end else if (sel < 29) begin
      track_bytes.push_back({($urandom_range(0, 1) ? STAT_PROGRAM : STAT_CHAN_TOUCH), ch});
      track_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (sel < 36) begin
      case ($urandom_range(0, 2))
        0: track_bytes.push_back({STAT_KEY_TOUCH, ch});
        1: track_bytes.push_back({STAT_CONTROL, ch});
        default: track_bytes.push_back({STAT_PITCH, ch});
      endcase
      track_bytes.push_back(8'($urandom_range(0, 127)));
      track_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (sel < 44) begin
      track_bytes.push_back(STAT_META);
      track_bytes.push_back(8'($urandom_range(0, 127)));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      track_bytes.push_back(8'(len));
      repeat (len) track_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 48) begin
      track_bytes.push_back(8'($urandom_range(SYS_FIRST, SYS_LAST)));
    end else begin
      track_bytes.push_back(8'($urandom_range(0, 127)));
      track_bytes.push_back(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic put_track();
    int unsigned nev;
    int unsigned cut;
    nev = $urandom_range(1, 10);
    repeat (nev) begin
      put_delta();
      put_event();
    end
    put_delta();
    track_bytes.push_back(STAT_META);
    track_bytes.push_back(META_END);
    track_bytes.push_back(8'h00);
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, track_bytes.size() - 1);
      while (track_bytes.size() > cut + 1) begin
        void'(track_bytes.pop_back());
      end
    end
    flush_track();
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 16)) track_bytes.push_back(8'($urandom_range(0, 255)));
    flush_track();
  endtask

  initial begin
    clear_track();
    // Notes, an overflowing delta, skipped events, a warning and two meta events.
    track_bytes = '{8'h00, {STAT_NOTE_ON, 4'h0}, 8'h3C, 8'h40,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {STAT_NOTE_OFF, 4'hF}, 8'hFF, 8'h7F,
                    8'h00, {STAT_NOTE_ON, 4'hF}, 8'h80, 8'h00,
                    8'h00, {STAT_PROGRAM, 4'h3}, 8'h12,
                    8'h00, {STAT_PITCH, 4'h2}, 8'h05, 8'h06,
                    8'h00, SYS_FIRST,
                    8'h00, STAT_META, 8'h01, 8'h01, 8'h41,
                    8'h00, STAT_META, META_END, 8'h00};
    flush_track();
    // A note cut short by the end of the track.
    track_bytes = '{8'h00, {STAT_NOTE_ON, 4'hA}, 8'h3C};
    flush_track();
    // Running status halts the track until its last byte.
    track_bytes = '{8'h00, 8'h40, 8'h11, 8'h22};
    flush_track();
    // A fatal error on the last byte of a track.
    track_bytes = '{8'h00, 8'h45};
    flush_track();
    while (pending_q.size() < 500) begin
      if ($urandom_range(0, 9) == 0) begin
        put_noise();
      end else begin
        put_track();
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_word_i <= pending_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
      rx_tick <= 0;
      rx_mode <= RX_OPEN;
      pressure_done <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (!pressure_done && bytes_taken >= 200) begin
        pressure_done <= 1'b1;
        hold_left <= 300;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode <= rx_mode_e'($urandom_range(0, 3));
          mode_left <= $urandom_range(8, 64);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (rx_tick % 5) < 2;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_results(in_word_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("result word arrived with nothing expected");
        end else begin
          oldest = expected_q.pop_front();
          check_field("kind", out_word_o.kind, oldest.kind);
          check_field("note_on", out_word_o.note_on, oldest.note_on);
          check_field("channel", out_word_o.channel, oldest.channel);
          check_field("note_number", out_word_o.note_number, oldest.note_number);
          check_field("velocity", out_word_o.velocity, oldest.velocity);
          check_field("delta_time", out_word_o.delta_time, oldest.delta_time);
          check_field("note_count", out_word_o.note_count, oldest.note_count);
          check_field("error_code", out_word_o.error_code, oldest.error_code);
          check_field("last", out_word_o.last, oldest.last);
        end
      end
    end
  end

endmodule

>>> midi_note_event_extractor_top.f
rtl/mnee_pkg.sv
rtl/midi_note_event_extractor_top.sv
tb/tb_top.sv
